### rtl/pvs_pkg.sv
// Shared constants and types for the perspective vertex-to-screen block.
// No dependencies.
`default_nettype none
package pvs_pkg;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int SCREEN_BITS_DEF = 16;

  localparam int COEF_W  = 32;
  localparam int DIM_W   = 13;
  localparam int SPAN_W  = 31;
  localparam int NUM_W   = 64;
  localparam int OUT_W   = 16;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SPAN   = 2'd2;

  localparam logic [DIM_W-1:0]  WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 13'd480;
  localparam logic [SPAN_W-1:0] SPAN_RST   = 31'd65536;

  localparam logic MODE_COEF = 1'b0;
  localparam logic MODE_VERT = 1'b1;

  typedef struct packed {
    logic                     valid;
    logic signed [COEF_W-1:0] x;
    logic signed [COEF_W-1:0] y;
    logic signed [COEF_W-1:0] z;
    logic signed [COEF_W-1:0] w;
  } pvs_clip_t;

  // per-beat flags carried alongside the dividers
  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
    logic neg_z;
    logic vis;
    logic wz;
  } pvs_side_t;
endpackage
`default_nettype wire

### rtl/perspective_vertex_to_screen.sv
// Top level: configuration registers, viewport setup stages, three divider lanes, output stage.
// Depends on pvs_pkg, pvs_xform, pvs_div_lane.
//
//  channel  | handshake                    | payload
//  input    | in_valid / in_ready          | mode, coef_index, coef_value, vert_x..vert_w
//  output   | out_valid / out_ready        | screen_x, screen_y, screen_depth, visible, w_zero
//  config   | cfg_we                       | cfg_index, cfg_data
//
// One beat per cycle while the output does not stall. Result path, in order: two matrix stages,
// two setup stages, one divider stage per quotient bit, output stage.
// Coefficient beats give no result. The whole pipe advances
// together; when a result waits on out_ready, every stage holds and in_ready drops.
// Synchronous reset loads the identity matrix and the default viewport.
`default_nettype none
module perspective_vertex_to_screen #(
  parameter int FRAC_BITS   = pvs_pkg::FRAC_BITS_DEF,
  parameter int SCREEN_BITS = pvs_pkg::SCREEN_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               mode,
  input  wire logic [3:0]                         coef_index,
  input  wire logic signed [pvs_pkg::COEF_W-1:0]  coef_value,
  input  wire logic signed [pvs_pkg::COEF_W-1:0]  vert_x,
  input  wire logic signed [pvs_pkg::COEF_W-1:0]  vert_y,
  input  wire logic signed [pvs_pkg::COEF_W-1:0]  vert_z,
  input  wire logic signed [pvs_pkg::COEF_W-1:0]  vert_w,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [pvs_pkg::OUT_W-1:0]        screen_x,
  output logic signed [pvs_pkg::OUT_W-1:0]        screen_y,
  output logic signed [pvs_pkg::OUT_W-1:0]        screen_depth,
  output logic                                    visible,
  output logic                                    w_zero,
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [pvs_pkg::SPAN_W-1:0]         cfg_data
);
  localparam int CW = pvs_pkg::COEF_W;
  localparam int NW = pvs_pkg::NUM_W;
  localparam int QB = SCREEN_BITS;

  logic                         adv;
  logic [pvs_pkg::DIM_W-1:0]    scr_w;
  logic [pvs_pkg::DIM_W-1:0]    scr_h;
  logic [pvs_pkg::SPAN_W-1:0]   span;
  pvs_pkg::pvs_clip_t           clip;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= pvs_pkg::WIDTH_RST;
      scr_h <= pvs_pkg::HEIGHT_RST;
      span  <= pvs_pkg::SPAN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pvs_pkg::REG_WIDTH:  scr_w <= cfg_data[pvs_pkg::DIM_W-1:0];
        pvs_pkg::REG_HEIGHT: scr_h <= cfg_data[pvs_pkg::DIM_W-1:0];
        pvs_pkg::REG_SPAN:   span  <= cfg_data;
        default: ;
      endcase
    end
  end

  pvs_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk(clk), .rst(rst), .adv(adv), .beat(in_valid && in_ready),
    .mode(mode), .coef_index(coef_index), .coef_value(coef_value),
    .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z), .vert_w(vert_w),
    .clip(clip)
  );

  // setup stage A: magnitudes and signs
  logic signed [CW:0] sx, sy;
  logic [CW:0]        mx_d, my_d;
  logic [CW-1:0]      mz_d, mw_d;
  pvs_pkg::pvs_side_t sa_d;

  always_comb begin
    sx = {clip.x[CW-1], clip.x} + {clip.w[CW-1], clip.w};
    sy = {clip.w[CW-1], clip.w} - {clip.y[CW-1], clip.y};
    mx_d = sx[CW] ? -sx : sx;
    my_d = sy[CW] ? -sy : sy;
    mz_d = clip.z[CW-1] ? -clip.z : clip.z;
    mw_d = clip.w[CW-1] ? -clip.w : clip.w;
    sa_d.valid = clip.valid;
    sa_d.wz    = clip.w == '0;
    sa_d.neg_x = sx[CW] != clip.w[CW-1];
    sa_d.neg_y = sy[CW] != clip.w[CW-1];
    sa_d.neg_z = clip.z != '0 && (clip.z[CW-1] == clip.w[CW-1]);
    sa_d.vis   = clip.w[CW-1] ? (clip.z > clip.w) : (clip.z < clip.w);
  end

  logic [CW:0]        mx, my;
  logic [CW-1:0]      mz, mw;
  pvs_pkg::pvs_side_t sa;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.valid <= 1'b0;
    end else if (adv) begin
      sa.valid <= sa_d.valid;
    end
    if (adv) begin
      mx <= mx_d;
      my <= my_d;
      mz <= mz_d;
      mw <= mw_d;
      {sa.neg_x, sa.neg_y, sa.neg_z, sa.vis, sa.wz} <=
        {sa_d.neg_x, sa_d.neg_y, sa_d.neg_z, sa_d.vis, sa_d.wz};
    end
  end

  // setup stage B: numerators and denominators
  logic [CW+pvs_pkg::DIM_W:0]    px, py;
  logic [CW+pvs_pkg::SPAN_W-1:0] pz;
  logic [NW-1:0]                 nx, ny, nz, dxy, dz;
  pvs_pkg::pvs_side_t            sb;

  assign px = mx * scr_w;
  assign py = my * scr_h;
  assign pz = mz * span;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb.valid <= 1'b0;
    end else if (adv) begin
      sb.valid <= sa.valid;
    end
    if (adv) begin
      nx  <= NW'(px);
      ny  <= NW'(py);
      nz  <= NW'(pz);
      dxy <= NW'({mw, 1'b0});
      dz  <= NW'(mw) << FRAC_BITS;
      {sb.neg_x, sb.neg_y, sb.neg_z, sb.vis, sb.wz} <=
        {sa.neg_x, sa.neg_y, sa.neg_z, sa.vis, sa.wz};
    end
  end

  logic [QB-1:0] qx, qy, qz;
  logic          ox, oy, oz;

  pvs_div_lane #(.QB(QB)) u_div_x (
    .clk(clk), .adv(adv), .num(nx), .den(dxy), .quo(qx), .ovf(ox));
  pvs_div_lane #(.QB(QB)) u_div_y (
    .clk(clk), .adv(adv), .num(ny), .den(dxy), .quo(qy), .ovf(oy));
  pvs_div_lane #(.QB(QB)) u_div_z (
    .clk(clk), .adv(adv), .num(nz), .den(dz), .quo(qz), .ovf(oz));

  // flags ride alongside the divider stages
  pvs_pkg::pvs_side_t side [QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QB; k++) side[k].valid <= 1'b0;
    end else if (adv) begin
      side[0].valid <= sb.valid;
      for (int k = 1; k < QB; k++) side[k].valid <= side[k-1].valid;
    end
    if (adv) begin
      {side[0].neg_x, side[0].neg_y, side[0].neg_z, side[0].vis, side[0].wz} <=
        {sb.neg_x, sb.neg_y, sb.neg_z, sb.vis, sb.wz};
      for (int k = 1; k < QB; k++) begin
        {side[k].neg_x, side[k].neg_y, side[k].neg_z, side[k].vis, side[k].wz} <=
          {side[k-1].neg_x, side[k-1].neg_y, side[k-1].neg_z, side[k-1].vis,
           side[k-1].wz};
      end
    end
  end

  function automatic logic [pvs_pkg::OUT_W-1:0] sat_q(input logic neg, input logic ovf,
                                                      input logic [QB-1:0] q);
    logic [QB-1:0] lim;
    logic [QB-1:0] mag;
    logic [31:0]   res;
    lim = neg ? (QB'(1) << (QB - 1)) : ((QB'(1) << (QB - 1)) - QB'(1));
    mag = (ovf || q > lim) ? lim : q;
    res = neg ? -(32'(mag)) : 32'(mag);
    return res[pvs_pkg::OUT_W-1:0];
  endfunction

  pvs_pkg::pvs_side_t so;

  assign so = side[QB-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= so.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_zero <= so.wz;
      if (so.wz) begin
        screen_x     <= '0;
        screen_y     <= '0;
        screen_depth <= '0;
        visible      <= 1'b0;
      end else begin
        screen_x     <= sat_q(so.neg_x, ox, qx);
        screen_y     <= sat_q(so.neg_y, oy, qy);
        screen_depth <= sat_q(so.neg_z, oz, qz);
        visible      <= so.vis;
      end
    end
  end

  a_wzero_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && w_zero |-> screen_x == '0 && screen_y == '0 && screen_depth == '0
                            && !visible)
    else $error("w_zero result carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !sa.valid && !sb.valid)
    else $error("pipeline valid set right after reset");

  a_stall_backs_up: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_depth))
    else $error("stalled result changed");
endmodule
`default_nettype wire

### rtl/pvs_xform.sv
// Matrix store and 4x4 matrix-vector product: products stage, then sum/saturate stage.
// Depends on pvs_pkg.
`default_nettype none
module pvs_xform #(
  parameter int FRAC_BITS = pvs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              adv,
  input  wire logic                              beat,
  input  wire logic                              mode,
  input  wire logic [3:0]                        coef_index,
  input  wire logic signed [pvs_pkg::COEF_W-1:0] coef_value,
  input  wire logic signed [pvs_pkg::COEF_W-1:0] vert_x,
  input  wire logic signed [pvs_pkg::COEF_W-1:0] vert_y,
  input  wire logic signed [pvs_pkg::COEF_W-1:0] vert_z,
  input  wire logic signed [pvs_pkg::COEF_W-1:0] vert_w,
  output pvs_pkg::pvs_clip_t                     clip
);
  localparam int CW = pvs_pkg::COEF_W;
  localparam int PW = 2 * CW;
  localparam int SW = PW + 2;

  // signed 32-bit clip limits at accumulator width
  localparam logic signed [SW-1:0] CLIP_MAX = (SW'(1) <<< (CW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] CLIP_MIN = -(SW'(1) <<< (CW - 1));

  logic signed [CW-1:0] mat [16];
  logic signed [CW-1:0] vin [4];
  logic signed [PW-1:0] prod [16];
  logic                 s1_valid;
  logic signed [CW-1:0] cres [4];

  assign vin[0] = vert_x;
  assign vin[1] = vert_y;
  assign vin[2] = vert_z;
  assign vin[3] = vert_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= ((i >> 2) == (i & 3)) ? CW'(1 << FRAC_BITS) : '0;
      end
    end else if (beat && mode == pvs_pkg::MODE_COEF) begin
      mat[coef_index] <= coef_value;
    end
  end

  // index is column*4+row; product slot is row*4+column
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 4; k++) begin
          prod[r*4+k] <= mat[k*4+r] * vin[k];
        end
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        acc = acc + SW'(prod[r*4+k] >>> FRAC_BITS);
      end
      if (acc > CLIP_MAX) cres[r] = {1'b0, {(CW-1){1'b1}}};
      else if (acc < CLIP_MIN) cres[r] = {1'b1, {(CW-1){1'b0}}};
      else cres[r] = acc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      clip.valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= beat && mode == pvs_pkg::MODE_VERT;
      clip.valid <= s1_valid;
    end
    if (adv) begin
      clip.x <= cres[0];
      clip.y <= cres[1];
      clip.z <= cres[2];
      clip.w <= cres[3];
    end
  end
endmodule
`default_nettype wire

### rtl/pvs_div_lane.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on pvs_pkg.
`default_nettype none
module pvs_div_lane #(
  parameter int QB = pvs_pkg::SCREEN_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       adv,
  input  wire logic [pvs_pkg::NUM_W-1:0]  num,
  input  wire logic [pvs_pkg::NUM_W-1:0]  den,
  output logic      [QB-1:0]              quo,
  output logic                            ovf
);
  localparam int NW = pvs_pkg::NUM_W;

  logic [NW-1:0] rem_r [QB];
  logic [NW-1:0] den_r [QB];
  logic [QB-1:0] quo_r [QB];
  logic          ovf_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int BIT = QB - 1 - k;
    logic [NW-1:0]    rem_in;
    logic [NW-1:0]    den_in;
    logic [QB-1:0]    quo_in;
    logic             ovf_in;
    logic [NW+QB-1:0] dsh;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
      // quotient would not fit in QB bits
      assign ovf_in = {{QB{1'b0}}, num} >= {den, {QB{1'b0}}};
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
      assign ovf_in = ovf_r[k-1];
    end

    assign dsh  = {{QB{1'b0}}, den_in} << BIT;
    assign take = {{QB{1'b0}}, rem_in} >= dsh;

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= take ? rem_in - dsh[NW-1:0] : rem_in;
        den_r[k] <= den_in;
        quo_r[k] <= quo_in | (take ? QB'(1) << BIT : '0);
        ovf_r[k] <= ovf_in;
      end
    end
  end

  assign quo = quo_r[QB-1];
  assign ovf = ovf_r[QB-1];
endmodule
`default_nettype wire
